[rtl/camera_point_projection_defines.svh]
// Assertion macros shared by the checker of the camera point projection block.
`ifndef CAMERA_POINT_PROJECTION_DEFINES_SVH
`define CAMERA_POINT_PROJECTION_DEFINES_SVH

// Checks a property on the rising clock edge while reset is released.
`define CPP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks a property on the rising clock edge, also during reset.
`define CPP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/cpp_pkg.sv]
// Types, register indexes and the sine table of the camera point projection block.
package cpp_pkg;

    typedef enum logic [2:0] {
        REG_CAM_X       = 3'd0,
        REG_CAM_Y       = 3'd1,
        REG_CAM_Z       = 3'd2,
        REG_YAW_DEG     = 3'd3,
        REG_PITCH_DEG   = 3'd4,
        REG_HALF_WIDTH  = 3'd5,
        REG_HALF_HEIGHT = 3'd6
    } cfg_reg_t;

    localparam logic [10:0] HALF_WIDTH_RST  = 11'd320;
    localparam logic [10:0] HALF_HEIGHT_RST = 11'd240;
    localparam int          QBITS           = 17;
    localparam int          REM_W           = 50;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [31:0] view_x;
        logic signed [31:0] view_y;
        logic signed [31:0] view_z;
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               in_view;
        logic               behind;
    } result_t;

    typedef struct packed {
        logic signed [15:0] cy;
        logic signed [15:0] sy;
        logic signed [15:0] cp;
        logic signed [15:0] sp;
    } trig_t;

    typedef struct packed {
        logic signed [45:0] nx;
        logic signed [45:0] ny;
        logic        [32:0] den;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic               in_view;
        logic               behind;
    } xform_t;

    typedef struct packed {
        logic [REM_W-1:0]   rx;
        logic [REM_W-1:0]   ry;
        logic [QBITS-1:0]   qx;
        logic [QBITS-1:0]   qy;
        logic               ovx;
        logic               ovy;
        logic               negx;
        logic               negy;
        logic        [32:0] den;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic               in_view;
        logic               behind;
    } div_t;

    localparam logic [14:0] QSINE [0:90] = '{
        15'd0, 15'd572, 15'd1144, 15'd1715, 15'd2286, 15'd2856, 15'd3425, 15'd3993,
        15'd4560, 15'd5126, 15'd5690, 15'd6252, 15'd6813, 15'd7371, 15'd7927, 15'd8481,
        15'd9032, 15'd9580, 15'd10126, 15'd10668, 15'd11207, 15'd11743, 15'd12275,
        15'd12803, 15'd13328, 15'd13848, 15'd14365, 15'd14876, 15'd15384, 15'd15886,
        15'd16384, 15'd16877, 15'd17364, 15'd17847, 15'd18324, 15'd18795, 15'd19261,
        15'd19720, 15'd20174, 15'd20622, 15'd21063, 15'd21498, 15'd21926, 15'd22348,
        15'd22763, 15'd23170, 15'd23571, 15'd23965, 15'd24351, 15'd24730, 15'd25102,
        15'd25466, 15'd25822, 15'd26170, 15'd26510, 15'd26842, 15'd27166, 15'd27482,
        15'd27789, 15'd28088, 15'd28378, 15'd28660, 15'd28932, 15'd29197, 15'd29452,
        15'd29698, 15'd29935, 15'd30163, 15'd30382, 15'd30592, 15'd30792, 15'd30983,
        15'd31164, 15'd31336, 15'd31499, 15'd31651, 15'd31795, 15'd31928, 15'd32052,
        15'd32166, 15'd32270, 15'd32365, 15'd32449, 15'd32524, 15'd32588, 15'd32643,
        15'd32688, 15'd32723, 15'd32748, 15'd32763, 15'd32767
    };

    function automatic logic signed [15:0] sine_of(input logic [9:0] a);
        logic [9:0]         r;
        logic [9:0]         t;
        logic               neg;
        logic signed [15:0] mag;
        r = (a >= 10'd360) ? a - 10'd360 : a;
        if (r <= 10'd90) begin
            t = r;
            neg = 1'b0;
        end else if (r <= 10'd180) begin
            t = 10'd180 - r;
            neg = 1'b0;
        end else if (r <= 10'd270) begin
            t = r - 10'd180;
            neg = 1'b1;
        end else begin
            t = 10'd360 - r;
            neg = 1'b1;
        end
        mag = $signed({1'b0, QSINE[t[6:0]]});
        return neg ? -mag : mag;
    endfunction

    function automatic logic signed [15:0] cosine_of(input logic [8:0] d);
        logic [9:0] r;
        r = (d >= 9'd360) ? 10'(d) - 10'd360 : 10'(d);
        return sine_of(r + 10'd90);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -38'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

[rtl/cpp_xform.sv]
// Six-stage camera transform: offset, yaw and pitch rotation, flags and numerators.
module cpp_xform
    import cpp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_vld,
    input  point_t             pin,
    input  logic signed [31:0] cam_x,
    input  logic signed [31:0] cam_y,
    input  logic signed [31:0] cam_z,
    input  trig_t              trig,
    input  logic        [10:0] half_height,
    output logic               out_vld,
    output xform_t             xout
);

    localparam logic signed [51:0] RND = 52'sd16384;

    logic [5:0] vld_reg;

    logic signed [32:0] dx_reg, dy_reg, dz_reg;
    logic signed [48:0] cydx_reg, sydz_reg, cydz_reg, sydx_reg;
    logic signed [32:0] dy2_reg, dy3_reg;
    logic signed [31:0] vx3_reg, vx4_reg, vx5_reg;
    logic signed [34:0] zr_reg;
    logic signed [50:0] cpzr_reg, spzr_reg;
    logic signed [48:0] cpdy_reg, spdy_reg;
    logic signed [31:0] vy5_reg, vz5_reg;
    xform_t             xf_reg;

    logic signed [51:0] xsum, zsum, ysum, vzsum;
    logic signed [45:0] px, py, nx_next, ny_next;
    logic signed [32:0] sx, sy, sz;
    logic        [32:0] ax, ay, az;
    logic               in_view_next;

    always_comb begin
        xsum  = 52'(cydx_reg) - 52'(sydz_reg) + RND;
        zsum  = 52'(cydz_reg) + 52'(sydx_reg) + RND;
        ysum  = 52'(cpdy_reg) - 52'(spzr_reg) + RND;
        vzsum = 52'(cpzr_reg) + 52'(spdy_reg) + RND;
    end

    always_comb begin
        px = vx5_reg * $signed({1'b0, half_height});
        py = vy5_reg * $signed({1'b0, half_height});
        nx_next = (px <<< 1) + 46'(vz5_reg);
        ny_next = (py <<< 1) + 46'(vz5_reg);
        sx = 33'(vx5_reg);
        sy = 33'(vy5_reg);
        sz = 33'(vz5_reg);
        ax = sx[32] ? 33'(-sx) : 33'(sx);
        ay = sy[32] ? 33'(-sy) : 33'(sy);
        az = sz[32] ? 33'(-sz) : 33'(sz);
        in_view_next = ({ax, 2'b00} < 35'({az, 2'b00}) + 35'(az)) && (ay < az);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[4:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg   <= 33'(pin.point_x) - 33'(cam_x);
            dy_reg   <= 33'(pin.point_y) - 33'(cam_y);
            dz_reg   <= 33'(pin.point_z) - 33'(cam_z);

            cydx_reg <= trig.cy * dx_reg;
            sydz_reg <= trig.sy * dz_reg;
            cydz_reg <= trig.cy * dz_reg;
            sydx_reg <= trig.sy * dx_reg;
            dy2_reg  <= dy_reg;

            vx3_reg  <= sat32(38'($signed(xsum[51:15])));
            zr_reg   <= 35'(zsum[51:15]);
            dy3_reg  <= dy2_reg;

            cpzr_reg <= trig.cp * zr_reg;
            spzr_reg <= trig.sp * zr_reg;
            cpdy_reg <= trig.cp * dy3_reg;
            spdy_reg <= trig.sp * dy3_reg;
            vx4_reg  <= vx3_reg;

            vy5_reg  <= sat32(-(38'($signed(ysum[51:15]))));
            vz5_reg  <= sat32(38'($signed(vzsum[51:15])));
            vx5_reg  <= vx4_reg;

            xf_reg.nx      <= nx_next;
            xf_reg.ny      <= ny_next;
            xf_reg.den     <= {vz5_reg, 1'b0};
            xf_reg.vx      <= vx5_reg;
            xf_reg.vy      <= vy5_reg;
            xf_reg.vz      <= vz5_reg;
            xf_reg.in_view <= in_view_next;
            xf_reg.behind  <= vz5_reg[31] || (vz5_reg == 32'sd0);
        end
    end

    assign out_vld = vld_reg[5];
    assign xout    = xf_reg;

endmodule

[rtl/cpp_proj.sv]
// Pipelined floor divider for both screen axes, one quotient bit a stage, with saturation.
module cpp_proj
    import cpp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        adv,
    input  logic        in_vld,
    input  xform_t      xin,
    input  logic [10:0] half_width,
    input  logic [10:0] half_height,
    output logic        out_vld,
    output result_t     rout
);

    logic [QBITS:0] vld_reg;
    div_t           dv_reg [0:QBITS];
    logic           res_vld_reg;
    result_t        res_reg;

    logic [REM_W-1:0] mx, my, dlim;
    div_t             dv0_next;

    function automatic logic signed [15:0] place(input logic [QBITS-1:0] q, input logic ov,
                                                 input logic neg, input logic [10:0] ctr);
        logic        [QBITS:0]   qm;
        logic signed [QBITS+2:0] qs;
        logic signed [QBITS+2:0] sum;
        qm  = ov ? (QBITS+1)'(1) << QBITS : {1'b0, q};
        qs  = $signed((QBITS+3)'(qm));
        qs  = neg ? ~qs : qs;
        sum = qs + $signed((QBITS+3)'(ctr));
        if (sum > (QBITS+3)'(32767)) begin
            return 16'sh7FFF;
        end else if (sum < -(QBITS+3)'(32768)) begin
            return 16'sh8000;
        end else begin
            return sum[15:0];
        end
    endfunction

    always_comb begin
        mx   = REM_W'(xin.nx[45] ? ~xin.nx : xin.nx);
        my   = REM_W'(xin.ny[45] ? ~xin.ny : xin.ny);
        dlim = REM_W'(xin.den) << QBITS;
        dv0_next.rx      = mx;
        dv0_next.ry      = my;
        dv0_next.qx      = '0;
        dv0_next.qy      = '0;
        dv0_next.ovx     = mx >= dlim;
        dv0_next.ovy     = my >= dlim;
        dv0_next.negx    = xin.nx[45];
        dv0_next.negy    = xin.ny[45];
        dv0_next.den     = xin.den;
        dv0_next.vx      = xin.vx;
        dv0_next.vy      = xin.vy;
        dv0_next.vz      = xin.vz;
        dv0_next.in_view = xin.in_view;
        dv0_next.behind  = xin.behind;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            res_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[QBITS-1:0], in_vld};
            res_vld_reg <= vld_reg[QBITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_reg[0] <= dv0_next;
        end
    end

    for (genvar j = 0; j < QBITS; j++) begin : g_div
        localparam int K = QBITS - 1 - j;
        logic [REM_W-1:0] dsh;
        div_t             dv_next;

        always_comb begin
            dsh     = REM_W'(dv_reg[j].den) << K;
            dv_next = dv_reg[j];
            if (dv_reg[j].rx >= dsh) begin
                dv_next.rx    = dv_reg[j].rx - dsh;
                dv_next.qx[K] = 1'b1;
            end
            if (dv_reg[j].ry >= dsh) begin
                dv_next.ry    = dv_reg[j].ry - dsh;
                dv_next.qy[K] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_reg[j+1] <= dv_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg.view_x  <= dv_reg[QBITS].vx;
            res_reg.view_y  <= dv_reg[QBITS].vy;
            res_reg.view_z  <= dv_reg[QBITS].vz;
            res_reg.in_view <= dv_reg[QBITS].in_view;
            res_reg.behind  <= dv_reg[QBITS].behind;
            if (dv_reg[QBITS].behind) begin
                res_reg.screen_x <= '0;
                res_reg.screen_y <= '0;
            end else begin
                res_reg.screen_x <= place(dv_reg[QBITS].qx, dv_reg[QBITS].ovx,
                                          dv_reg[QBITS].negx, half_width);
                res_reg.screen_y <= place(dv_reg[QBITS].qy, dv_reg[QBITS].ovy,
                                          dv_reg[QBITS].negy, half_height);
            end
        end
    end

    assign out_vld = res_vld_reg;
    assign rout    = res_reg;

endmodule

[rtl/camera_point_projection.sv]
// Top level of the camera point projection block: configuration registers and pipeline.
//
//  Channel  Ports                          Moves
//  s_       s_valid s_ready s_data         world point item (point_t)
//  m_       m_valid m_ready m_data         projected result item (result_t)
//  cfg_     cfg_we cfg_index cfg_data      camera and screen register writes
//
// One item enters per cycle while the output does not stall. The path from input
// to output has six transform stages, one sign and range stage, 17 divider stages
// (one quotient bit each) and the output register. The whole pipeline holds while
// the output waits. Reset clears all valid bits and loads the register reset values.
module camera_point_projection
    import cpp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  point_t      s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output result_t     m_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic signed [31:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic        [8:0]  yaw_reg, pitch_reg;
    logic        [10:0] half_width_reg, half_height_reg;

    trig_t  trig;
    logic   adv;
    logic   xf_vld;
    xform_t xf;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg       <= '0;
            cam_y_reg       <= '0;
            cam_z_reg       <= '0;
            yaw_reg         <= '0;
            pitch_reg       <= '0;
            half_width_reg  <= HALF_WIDTH_RST;
            half_height_reg <= HALF_HEIGHT_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CAM_X:       cam_x_reg       <= cfg_data;
                REG_CAM_Y:       cam_y_reg       <= cfg_data;
                REG_CAM_Z:       cam_z_reg       <= cfg_data;
                REG_YAW_DEG:     yaw_reg         <= cfg_data[8:0];
                REG_PITCH_DEG:   pitch_reg       <= cfg_data[8:0];
                REG_HALF_WIDTH:  half_width_reg  <= cfg_data[10:0];
                REG_HALF_HEIGHT: half_height_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        trig.cy = cosine_of(yaw_reg);
        trig.sy = sine_of({1'b0, yaw_reg});
        trig.cp = cosine_of(pitch_reg);
        trig.sp = sine_of({1'b0, pitch_reg});
    end

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    cpp_xform u_xform (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .in_vld      (s_valid),
        .pin         (s_data),
        .cam_x       (cam_x_reg),
        .cam_y       (cam_y_reg),
        .cam_z       (cam_z_reg),
        .trig        (trig),
        .half_height (half_height_reg),
        .out_vld     (xf_vld),
        .xout        (xf)
    );

    cpp_proj u_proj (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .in_vld      (xf_vld),
        .xin         (xf),
        .half_width  (half_width_reg),
        .half_height (half_height_reg),
        .out_vld     (m_valid),
        .rout        (m_data)
    );

endmodule

[rtl/cpp_checker.sv]
// Port-level checker of the camera point projection block and its bind statement.
`include "camera_point_projection_defines.svh"

module cpp_checker
    import cpp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input result_t     m_data
);

    `CPP_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result item dropped or changed while stalled")
    `CPP_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_valid, "result valid after reset")
    `CPP_ASSERT(a_behind, aclk, aresetn, m_valid |-> (m_data.behind == (m_data.view_z[31] || m_data.view_z == 32'sd0)), "behind flag disagrees with depth")
    `CPP_ASSERT(a_zero, aclk, aresetn, m_valid && m_data.behind |-> m_data.screen_x == 16'sd0 && m_data.screen_y == 16'sd0 && !(m_data.in_view && m_data.view_z == 32'sd0), "screen not cleared for point behind camera")

endmodule

bind camera_point_projection cpp_checker u_cpp_checker (.*);
